// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/cbm_pkg.sv -----
`timescale 1ns / 1ps

package cbm_pkg;

    typedef enum logic [2:0] {
        CMD_ROM_READ  = 3'd0,
        CMD_REG_WRITE = 3'd1,
        CMD_RAM_READ  = 3'd2,
        CMD_RAM_WRITE = 3'd3,
        CMD_ROM_LOAD  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_ROM   = 2'd1,
        SRC_RAM   = 2'd2
    } t_src;

    typedef struct packed {
        logic       rom_rd;
        logic       rom_wr;
        logic       ram_rd;
        logic       ram_wr;
        t_src       src;
        logic [7:0] const_data;
        logic       status;
    } t_ctrl;

    localparam int ROM_OFF_W = 14;
    localparam int RAM_OFF_W = 13;

    localparam logic [15:0] ADDR_REG_ROM_BANK = 16'h2000;
    localparam logic [15:0] ADDR_ROM_BANKED   = 16'h4000;
    localparam logic [15:0] ADDR_REG_LATCH    = 16'h6000;
    localparam logic [15:0] ADDR_ROM_TOP      = 16'h8000;
    localparam logic [15:0] ADDR_RAM_BASE     = 16'hA000;
    localparam logic [15:0] ADDR_RAM_LAST     = 16'hBFFF;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] READ_DISABLED  = 8'hFF;

endpackage

// ----- rtl/core/cbm_ram.sv -----
`timescale 1ns / 1ps

module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/cbm_ctrl.sv -----
`timescale 1ns / 1ps

module cbm_ctrl import cbm_pkg::*; #(
    parameter int ROM_BANKS = 128,
    parameter int RAM_BANKS = 4,
    localparam int ROM_BW   = $clog2(ROM_BANKS),
    localparam int RAM_BW   = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1,
    localparam int ROM_DEPTH = ROM_BANKS * (2 ** ROM_OFF_W),
    localparam int RAM_DEPTH = RAM_BANKS * (2 ** RAM_OFF_W),
    localparam int ROM_AW   = $clog2(ROM_DEPTH),
    localparam int RAM_AW   = $clog2(RAM_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [2:0]        i_cmd,
    input  logic [20:0]       i_address,
    input  logic [7:0]        i_data,
    output t_ctrl             o_ctrl,
    output logic [ROM_AW-1:0] o_rom_addr,
    output logic [RAM_AW-1:0] o_ram_addr
);

    logic              r_ram_enable;
    logic [ROM_BW-1:0] r_rom_bank;
    logic [RAM_BW-1:0] r_ram_bank;
    logic              n_ram_enable;
    logic [ROM_BW-1:0] n_rom_bank;
    logic [RAM_BW-1:0] n_ram_bank;

    logic        bus_ok;
    logic [15:0] bus_addr;
    logic        in_ram;
    logic [6:0]  rom_raw;
    t_ctrl       ctrl;

    // restoring reduction of a narrow bank number by the built bank count
    function automatic logic [ROM_BW-1:0] f_rom_mod(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        for (int k = 6; k >= 0; k--) begin
            if (14'(r) >= (14'(ROM_BANKS) << k)) begin
                r = 7'(14'(r) - (14'(ROM_BANKS) << k));
            end
        end
        return ROM_BW'(r);
    endfunction

    function automatic logic [RAM_BW-1:0] f_ram_mod(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        for (int k = 3; k >= 0; k--) begin
            if (8'(r) >= (8'(RAM_BANKS) << k)) begin
                r = 4'(8'(r) - (8'(RAM_BANKS) << k));
            end
        end
        return RAM_BW'(r);
    endfunction

    assign bus_addr = i_address[15:0];
    assign bus_ok   = (i_address[20:16] == 5'd0);
    assign in_ram   = bus_ok && (bus_addr >= ADDR_RAM_BASE) && (bus_addr <= ADDR_RAM_LAST);
    assign rom_raw  = (i_data[6:0] == 7'd0) ? 7'd1 : i_data[6:0];

    always_comb begin
        ctrl         = '0;
        ctrl.src     = SRC_CONST;
        n_ram_enable = r_ram_enable;
        n_rom_bank   = r_rom_bank;
        n_ram_bank   = r_ram_bank;
        o_rom_addr   = ROM_AW'({r_rom_bank, bus_addr[ROM_OFF_W-1:0]});
        o_ram_addr   = RAM_AW'({r_ram_bank, bus_addr[RAM_OFF_W-1:0]});
        case (i_cmd)
            CMD_ROM_READ: begin
                if (bus_ok && (bus_addr < ADDR_ROM_BANKED)) begin
                    ctrl.rom_rd = 1'b1;
                    ctrl.src    = SRC_ROM;
                    o_rom_addr  = ROM_AW'(bus_addr[ROM_OFF_W-1:0]);
                end else if (bus_ok && (bus_addr < ADDR_ROM_TOP)) begin
                    ctrl.rom_rd = 1'b1;
                    ctrl.src    = SRC_ROM;
                end else begin
                    ctrl.status = 1'b1;
                end
            end
            CMD_REG_WRITE: begin
                if (!bus_ok || (bus_addr >= ADDR_ROM_TOP)) begin
                    ctrl.status = 1'b1;
                end else if (bus_addr < ADDR_REG_ROM_BANK) begin
                    n_ram_enable = (i_data[3:0] == RAM_ENABLE_KEY);
                end else if (bus_addr < ADDR_ROM_BANKED) begin
                    n_rom_bank = f_rom_mod(rom_raw);
                end else if (bus_addr < ADDR_REG_LATCH) begin
                    n_ram_bank = f_ram_mod(i_data[3:0]);
                end
            end
            CMD_RAM_READ: begin
                if (!r_ram_enable) begin
                    ctrl.const_data = READ_DISABLED;
                end else if (in_ram) begin
                    ctrl.ram_rd = 1'b1;
                    ctrl.src    = SRC_RAM;
                end else begin
                    ctrl.status = 1'b1;
                end
            end
            CMD_RAM_WRITE: begin
                if (r_ram_enable) begin
                    if (in_ram) begin
                        ctrl.ram_wr = 1'b1;
                    end else begin
                        ctrl.status = 1'b1;
                    end
                end
            end
            CMD_ROM_LOAD: begin
                ctrl.rom_wr = ({1'b0, i_address} < 22'(ROM_DEPTH));
                o_rom_addr  = i_address[ROM_AW-1:0];
            end
            default: begin
                ctrl.status = 1'b1;
            end
        endcase
    end

    assign o_ctrl = ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enable <= 1'b0;
            r_rom_bank   <= ROM_BW'(1);
            r_ram_bank   <= '0;
        end else if (i_en) begin
            r_ram_enable <= n_ram_enable;
            r_rom_bank   <= n_rom_bank;
            r_ram_bank   <= n_ram_bank;
        end
    end

endmodule

// ----- rtl/core/cartridge_bank_mapper.sv -----
// pipeline: each accepted request is registered in stage s1 alongside the memory read, then in the output register
// throughput: one request per cycle while o_ready is high (not during clearing or output stall), one result per request
// bank registers and the ROM and save-RAM memories each take one access per cycle
// reset: ram disabled, rom bank 1, ram bank 0; save ram then cleared to zero
// clearing writes zero to every save ram address with no request accepted; rom is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cartridge_bank_mapper import cbm_pkg::*; #(
    parameter int ROM_BANKS = 128,
    parameter int RAM_BANKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [20:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_status
);

    localparam int ROM_DEPTH = ROM_BANKS * (2 ** ROM_OFF_W);
    localparam int RAM_DEPTH = RAM_BANKS * (2 ** RAM_OFF_W);
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    t_ctrl             ctrl;
    logic [ROM_AW-1:0] rom_addr;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        rom_rdata;
    logic [7:0]        ram_rdata;
    logic              accept;
    logic              s1_move;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;

    logic              r_s1_valid;
    t_src              r_s1_src;
    logic [7:0]        r_s1_const;
    logic              r_s1_status;

    logic              r_out_valid;
    logic [7:0]        r_read_data;
    logic              r_status;
    logic [7:0]        n_read_data;

    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || s1_move);
    assign accept  = i_valid && o_ready;

    cbm_ctrl #(
        .ROM_BANKS(ROM_BANKS),
        .RAM_BANKS(RAM_BANKS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_cmd     (i_cmd),
        .i_address (i_address),
        .i_data    (i_data),
        .o_ctrl    (ctrl),
        .o_rom_addr(rom_addr),
        .o_ram_addr(ram_addr)
    );

    cbm_ram #(
        .WIDTH(8),
        .DEPTH(ROM_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_we   (accept && ctrl.rom_wr),
        .i_waddr(rom_addr),
        .i_wdata(i_data),
        .i_re   (accept && ctrl.rom_rd),
        .i_raddr(rom_addr),
        .o_rdata(rom_rdata)
    );

    // clearing sweep owns the write port until done
    assign ram_we    = r_clr_busy || (accept && ctrl.ram_wr);
    assign ram_waddr = r_clr_busy ? r_clr_addr : ram_addr;
    assign ram_wdata = r_clr_busy ? 8'd0 : i_data;

    cbm_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_save_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (accept && ctrl.ram_rd),
        .i_raddr(ram_addr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + RAM_AW'(1);
            if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_ROM: n_read_data = rom_rdata;
            SRC_RAM: n_read_data = ram_rdata;
            default: n_read_data = r_s1_const;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src    <= ctrl.src;
            r_s1_const  <= ctrl.const_data;
            r_s1_status <= ctrl.status;
        end
        if (s1_move) begin
            r_read_data <= n_read_data;
            r_status    <= r_s1_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;

    `ASSERT_NEVER(a_no_req_while_clearing, i_clk, i_rst_n, r_clr_busy && o_ready, "request taken during ram clear")
    `ASSERT_ALWAYS(a_accept_fills_stage, i_clk, i_rst_n, accept |=> r_s1_valid, "accepted request lost")
    `ASSERT_ALWAYS(a_stage_drains, i_clk, i_rst_n, (r_s1_valid && !r_out_valid) |=> r_out_valid, "pending result not moved out")
    `ASSERT_ALWAYS(a_unmapped_zero, i_clk, i_rst_n, (o_valid && o_status) |-> (o_read_data == 8'd0), "unmapped result with nonzero data")

endmodule
